### sv/pdscr_pkg.sv
// Shared types and constants for the PD source capability select and request unit.
package pdscr_pkg;

	localparam int CNT_W = 3;

	typedef enum logic [2:0] {
		KIND_FIXED    = 3'd0,
		KIND_BATTERY  = 3'd1,
		KIND_VARIABLE = 3'd2,
		KIND_PPS      = 3'd3,
		KIND_UNKNOWN  = 3'd4
	} pdo_kind_t;

	// PDO type field, bits 31:30
	localparam logic [1:0] PDO_TYPE_FIXED    = 2'd0;
	localparam logic [1:0] PDO_TYPE_BATTERY  = 2'd1;
	localparam logic [1:0] PDO_TYPE_VARIABLE = 2'd2;
	localparam logic [1:0] PDO_TYPE_AUGMENT  = 2'd3;

	// register indexes on the config port
	localparam logic REG_TARGET_MV = 1'b0;
	localparam logic REG_TARGET_MA = 1'b1;

	localparam logic [15:0] TARGET_MV_RST = 16'd5000;
	localparam logic [15:0] TARGET_MA_RST = 16'd0;

	// reciprocal multipliers for the request fields
	localparam logic [15:0] RECIP_DIV10 = 16'd52429;  // >> 19
	localparam logic [15:0] RECIP_DIV50 = 16'd41944;  // >> 21
	localparam logic [15:0] RECIP_DIV20 = 16'd52429;  // >> 20

	// one decoded word as it travels from front to back
	typedef struct packed {
		pdo_kind_t   kind;
		logic [15:0] min_mv;
		logic [15:0] max_mv;
		logic [13:0] max_ma;
		logic [2:0]  caps;     // {dual role, unconstrained, usb comm}
		logic        carries;
		logic        last;
	} pdo_entry_t;

	typedef struct packed {
		logic             found;
		logic [2:0]       position;
		logic             is_pps;
		logic [31:0]      request;
		logic [CNT_W-1:0] kept;
		logic [2:0]       caps;
	} sel_result_t;

endpackage

### sv/pdscr_front.sv
// Front part: accepts raw PDO words, decodes them and queues the decoded entries.
module pdscr_front
	import pdscr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] pdo_word,
	input  logic        carries_pdo,
	input  logic        last_item,
	output logic        q_valid,
	input  logic        q_pop,
	output pdo_entry_t  q_entry
);

	pdo_entry_t dec;
	pdo_entry_t fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;

	always_comb begin
		dec         = '0;
		dec.carries = carries_pdo;
		dec.last    = last_item;
		dec.caps    = {pdo_word[29], pdo_word[27], pdo_word[26]};
		unique case (pdo_word[31:30])
			PDO_TYPE_FIXED: begin
				dec.kind   = KIND_FIXED;
				dec.min_mv = {6'b0, pdo_word[19:10]} * 16'd50;
				dec.max_mv = {6'b0, pdo_word[19:10]} * 16'd50;
				dec.max_ma = {4'b0, pdo_word[9:0]} * 14'd10;
			end
			PDO_TYPE_BATTERY: begin
				dec.kind   = KIND_BATTERY;
				dec.max_mv = {6'b0, pdo_word[29:20]} * 16'd50;
				dec.min_mv = {6'b0, pdo_word[19:10]} * 16'd50;
			end
			PDO_TYPE_VARIABLE: begin
				dec.kind   = KIND_VARIABLE;
				dec.max_mv = {6'b0, pdo_word[29:20]} * 16'd50;
				dec.min_mv = {6'b0, pdo_word[19:10]} * 16'd50;
				dec.max_ma = {4'b0, pdo_word[9:0]} * 14'd10;
			end
			PDO_TYPE_AUGMENT: begin
				if (pdo_word[29:28] != 2'b00) begin
					dec.kind = KIND_UNKNOWN;
				end else begin
					dec.kind   = KIND_PPS;
					dec.max_mv = {8'b0, pdo_word[24:17]} * 16'd100;
					dec.min_mv = {8'b0, pdo_word[15:8]} * 16'd100;
					dec.max_ma = {7'b0, pdo_word[6:0]} * 14'd50;
				end
			end
			default: dec.kind = KIND_UNKNOWN;
		endcase
	end

	assign in_ready = (fill_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (fill_q != 2'd0);
	assign pop      = q_pop && q_valid;
	assign q_entry  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= dec;
	end

endmodule

### sv/pdscr_back.sv
// Back part: stores decoded profiles, scans them on the closing word and builds the request.
module pdscr_back
	import pdscr_pkg::*;
#(
	parameter int PROFILE_SLOTS = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_pop,
	input  pdo_entry_t  q_entry,
	input  logic [15:0] target_mv,
	input  logic [15:0] target_ma,
	output logic        res_valid,
	input  logic        res_ready,
	output sel_result_t res
);

	localparam int IDX_W = (PROFILE_SLOTS > 1) ? $clog2(PROFILE_SLOTS) : 1;
	localparam logic [CNT_W-1:0] SLOT_CNT = CNT_W'(PROFILE_SLOTS);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_SEL  = 4'b0100,
		ST_EMIT = 4'b1000
	} back_state_t;

	back_state_t state_q;

	pdo_kind_t   kind_q   [PROFILE_SLOTS];
	logic [15:0] min_mv_q [PROFILE_SLOTS];
	logic [15:0] max_mv_q [PROFILE_SLOTS];
	logic [13:0] max_ma_q [PROFILE_SLOTS];

	logic [CNT_W-1:0] count_q;
	logic [2:0]       caps_q;
	logic [IDX_W-1:0] idx_q;

	logic        fix_found_q;
	logic [2:0]  fix_pos_q;
	logic [13:0] fix_ma_q;
	logic        pps_found_q;
	logic [2:0]  pps_pos_q;
	logic [13:0] pps_ma_q;

	logic        sel_found_q;
	logic        sel_pps_q;
	logic [2:0]  sel_pos_q;
	logic [13:0] sel_ma_q;

	logic        out_valid_q;
	sel_result_t out_q;

	logic             pop;
	logic             store;
	logic [CNT_W-1:0] count_n;
	pdo_kind_t        rd_kind;
	logic [15:0]      rd_min;
	logic [15:0]      rd_max;
	logic [13:0]      rd_ma;
	logic             ma_ok;
	logic             fixed_hit;
	logic             pps_hit;
	logic             scan_end;
	logic [13:0]      pick_ma;
	logic [29:0]      ma_x10;
	logic [29:0]      ma_x50;
	logic [31:0]      mv_x20;
	logic [31:0]      req;
	logic             out_free;

	assign pop     = (state_q == ST_IDLE) && q_valid;
	assign q_pop   = pop;
	assign store   = pop && q_entry.carries && (count_q < SLOT_CNT);
	assign count_n = store ? count_q + 3'd1 : count_q;

	assign rd_kind = kind_q[idx_q];
	assign rd_min  = min_mv_q[idx_q];
	assign rd_max  = max_mv_q[idx_q];
	assign rd_ma   = max_ma_q[idx_q];

	assign ma_ok     = (target_ma == 16'd0) || ({2'b0, rd_ma} >= target_ma);
	assign fixed_hit = (rd_kind == KIND_FIXED) && (rd_max == target_mv) && ma_ok;
	assign pps_hit   = (rd_kind == KIND_PPS) && (rd_min <= target_mv) &&
	                   (target_mv <= rd_max) && ma_ok &&
	                   (!pps_found_q || (pps_ma_q < rd_ma));
	assign scan_end  = (CNT_W'(idx_q) == count_q - 3'd1);

	assign pick_ma = fix_found_q ? fix_ma_q : pps_ma_q;

	// reciprocal divides: ma/10, ma/50, target_mv/20
	assign ma_x10 = {2'b0, sel_ma_q} * {14'b0, RECIP_DIV10};
	assign ma_x50 = {2'b0, sel_ma_q} * {14'b0, RECIP_DIV50};
	assign mv_x20 = {16'b0, target_mv} * {16'b0, RECIP_DIV20};

	always_comb begin
		req = '0;
		if (sel_found_q) begin
			if (sel_pps_q) begin
				req = {1'b0, sel_pos_q, 7'b0, mv_x20[31:20], 2'b0, ma_x50[27:21]};
			end else begin
				req = {1'b0, sel_pos_q, 8'b0, ma_x10[28:19], ma_x10[28:19]};
			end
		end
	end

	assign out_free = !out_valid_q || res_ready;

	always_ff @(posedge clk) begin
		if (store) begin
			kind_q[count_q[IDX_W-1:0]]   <= q_entry.kind;
			min_mv_q[count_q[IDX_W-1:0]] <= q_entry.min_mv;
			max_mv_q[count_q[IDX_W-1:0]] <= q_entry.max_mv;
			max_ma_q[count_q[IDX_W-1:0]] <= q_entry.max_ma;
		end
		if (state_q == ST_SCAN) begin
			if (!fix_found_q && fixed_hit) begin
				fix_pos_q <= 3'(idx_q);
				fix_ma_q  <= rd_ma;
			end
			if (pps_hit) begin
				pps_pos_q <= 3'(idx_q);
				pps_ma_q  <= rd_ma;
			end
		end
		if (state_q == ST_SEL) begin
			sel_found_q <= fix_found_q || pps_found_q;
			sel_pps_q   <= !fix_found_q && pps_found_q;
			sel_pos_q   <= (fix_found_q ? fix_pos_q : pps_pos_q) + 3'd1;
			sel_ma_q    <= ((target_ma == 16'd0) || (target_ma > {2'b0, pick_ma})) ?
			               pick_ma : target_ma[13:0];
		end
		if ((state_q == ST_EMIT) && out_free) begin
			out_q.found    <= sel_found_q;
			out_q.position <= sel_found_q ? sel_pos_q : 3'd0;
			out_q.is_pps   <= sel_pps_q;
			out_q.request  <= req;
			out_q.kept     <= count_q;
			out_q.caps     <= caps_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			caps_q      <= '0;
			idx_q       <= '0;
			fix_found_q <= 1'b0;
			pps_found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= ((state_q == ST_EMIT) && out_free) || (out_valid_q && !res_ready);
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						count_q <= count_n;
						if (store && (count_q == '0) && (q_entry.kind == KIND_FIXED))
							caps_q <= q_entry.caps;
						if (q_entry.last) begin
							fix_found_q <= 1'b0;
							pps_found_q <= 1'b0;
							idx_q       <= '0;
							state_q     <= (count_n == '0) ? ST_SEL : ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (fixed_hit) fix_found_q <= 1'b1;
					if (pps_hit) pps_found_q <= 1'b1;
					idx_q <= idx_q + 1'b1;
					if (scan_end) state_q <= ST_SEL;
				end
				ST_SEL: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						count_q     <= '0;
						caps_q      <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

### sv/pd_source_caps_select_request_unit.sv
// Top level: config registers, PDO intake front, selection back and stream ports.
//
// Input stream (s_*): one PDO word per beat. s_tuser = 1 when s_tdata holds a PDO,
// s_tlast = 1 on the beat that closes the capabilities list. Only the closing beat
// produces a result word on the output stream (m_*).
// Config: target_mv at address 0 (reset 5000), target_ma at address 4 (reset 0,
// meaning take the profile maximum). Write them only while no list is in flight.
// A two-entry queue sits between intake and selection, so words keep flowing in
// while the back part is busy scanning or holding a result.
// Rate: non-closing words pass at one per cycle while the back part is idle.
// A closing word goes through the back part in order: pop, one scan step per stored
// profile, select and build; the result then shows on m_tvalid. The profile scan
// covers at most PROFILE_SLOTS entries.
// A result waits in the output register while m_tready is low; the back part then
// holds its next result in the build step and the queue fills; then s_tready drops.
// Reset clears the queue, the stored list count, the capability bits and the output
// valid; stored profiles are overwritten as a new list arrives.
module pd_source_caps_select_request_unit
	import pdscr_pkg::*;
#(
	parameter int PROFILE_SLOTS = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // pdo_word
	input  logic        s_tuser,   // carries_pdo
	input  logic        s_tlast,   // last_item
	output logic        m_tvalid,
	input  logic        m_tready,
	// found[0], chosen_position[3:1], request_word[35:4], profiles_kept[38:36],
	// comm_capable[39], unconstrained[40], dual_role[41], zero[47:42]
	output logic [47:0] m_tdata,
	output logic        m_tuser,   // chosen_is_pps
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0] target_mv_q;
	logic [15:0] target_ma_q;
	logic        cfg_wr;
	logic        q_valid;
	logic        q_pop;
	pdo_entry_t  q_entry;
	sel_result_t res;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_mv_q <= TARGET_MV_RST;
			target_ma_q <= TARGET_MA_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_TARGET_MV: target_mv_q <= pwdata[15:0];
				REG_TARGET_MA: target_ma_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_TARGET_MV: prdata = {16'b0, target_mv_q};
			REG_TARGET_MA: prdata = {16'b0, target_ma_q};
			default:       prdata = '0;
		endcase
	end

	pdscr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.pdo_word    (s_tdata),
		.carries_pdo (s_tuser),
		.last_item   (s_tlast),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_entry     (q_entry)
	);

	pdscr_back #(
		.PROFILE_SLOTS (PROFILE_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_entry   (q_entry),
		.target_mv (target_mv_q),
		.target_ma (target_ma_q),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {6'b0, res.caps, res.kept, res.request, res.position, res.found};
	assign m_tuser = res.is_pps;

endmodule
